>>> design/rse_pkg.sv
// Package for the RS(255,239) parity encoder: payload types, generator
// coefficients and the GF(256) constant multiply. No dependencies.
`timescale 1ns / 1ps

package rse_pkg;

    localparam int unsigned NUM_PARITY = 16;

    // x^8 + x^6 + x^5 + x^3 + 1
    localparam logic [8:0] FIELD_POLY = 9'h169;

    // Generator coefficients g[0]..g[15], g[0] in the low byte.
    localparam logic [NUM_PARITY-1:0][7:0] GEN_COEF = {
        8'hdb, 8'ha9, 8'hce, 8'hfd, 8'hfc, 8'h2f, 8'h1e, 8'h13,
        8'h44, 8'h9e, 8'h24, 8'ha1, 8'h1f, 8'h63, 8'he3, 8'h6a
    };

    localparam logic [3:0] LAST_INDEX = 4'(NUM_PARITY - 1);

    typedef logic [NUM_PARITY-1:0][7:0] t_block;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] parity_byte;
        logic [3:0] parity_index;
        logic       last_parity;
    } t_out;

    // Shift-and-add multiply in GF(256); with one constant operand this
    // folds to a small XOR network.
    function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b_in);
        logic [8:0] a;
        logic [7:0] acc;
        acc = '0;
        a   = {1'b0, a_in};
        for (int i = 0; i < 8; i++) begin
            if (b_in[i]) begin
                acc ^= a[7:0];
            end
            a = a << 1;
            if (a[8]) begin
                a ^= FIELD_POLY;
            end
        end
        return acc;
    endfunction

endpackage

>>> design/rse_front.sv
// Front end: takes message bytes and updates the 16-byte LFSR remainder.
// On the last byte it pushes the finished remainder to the queue. Uses rse_pkg.
`timescale 1ns / 1ps

module rse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rse_pkg::t_in      i_data,
    input  logic              i_full,
    output logic              o_push,
    output rse_pkg::t_block   o_block
);
    import rse_pkg::*;

    t_block     r_rem;
    t_block     n_rem;
    logic [7:0] fb;
    logic       accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign fb      = i_data.data_byte ^ r_rem[NUM_PARITY-1];

    always_comb begin
        n_rem[0] = gf_mul(fb, GEN_COEF[0]);
        for (int k = 1; k < NUM_PARITY; k++) begin
            n_rem[k] = r_rem[k-1] ^ gf_mul(fb, GEN_COEF[k]);
        end
    end

    assign o_push  = accept && i_data.last_byte;
    assign o_block = n_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (accept) begin
            // clear once the block's parity has left for the queue
            r_rem <= i_data.last_byte ? '0 : n_rem;
        end
    end

endmodule

>>> design/rse_fifo.sv
// Two-entry queue of finished parity blocks between front and back end.
// Uses rse_pkg.
`timescale 1ns / 1ps

module rse_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rse_pkg::t_block   i_block,
    input  logic              i_pop,
    output rse_pkg::t_block   o_block,
    output logic              o_full,
    output logic              o_empty
);
    import rse_pkg::*;

    t_block     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_block = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

>>> design/rse_back.sv
// Back end: unloads parity blocks from the queue and sends them out one
// byte per item through an output register. Uses rse_pkg.
`timescale 1ns / 1ps

module rse_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rse_pkg::t_block   i_block,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output rse_pkg::t_out     o_data
);
    import rse_pkg::*;

    t_block     r_blk;
    logic [3:0] r_cnt;
    logic       r_act;
    logic       r_out_valid;
    t_out       r_out;
    logic       advance;
    logic       emit;
    logic       emit_last;

    assign advance   = !r_out_valid || i_ready;
    assign emit      = advance && r_act;
    assign emit_last = emit && (r_cnt == LAST_INDEX);
    // take the next block when idle or as the current one finishes
    assign o_pop     = !i_empty && (!r_act || emit_last);

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.parity_byte  <= r_blk[0];
            r_out.parity_index <= r_cnt;
            r_out.last_parity  <= (r_cnt == LAST_INDEX);
        end
        if (o_pop) begin
            r_blk <= i_block;
        end else if (emit) begin
            r_blk <= {8'h00, r_blk[NUM_PARITY-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_act;
            end
            if (o_pop) begin
                r_act <= 1'b1;
                r_cnt <= '0;
            end else if (emit) begin
                r_act <= !emit_last;
                r_cnt <= r_cnt + 4'd1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.last_parity == (r_out.parity_index == LAST_INDEX)))
        else $error("last_parity disagrees with parity_index");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_ready && !r_out.last_parity) |=> r_out_valid)
        else $error("gap inside a parity block");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_ready && !r_out.last_parity) |=>
            (r_out.parity_index == $past(r_out.parity_index) + 4'd1))
        else $error("parity index skipped");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act && !emit_last) |-> !o_pop)
        else $error("queue popped during an unfinished block");
`endif

endmodule

>>> design/rs_255_239_parity_encoder.sv
// Top level of the RS(255,239) systematic parity encoder over GF(256).
// Instantiates rse_front, rse_fifo and rse_back; uses rse_pkg.
`timescale 1ns / 1ps

//  channel | handshake          | payload             | moves
//  --------+--------------------+---------------------+------------------------------
//  input   | i_valid / o_ready  | i_data  (t_in)      | one message byte per item
//  output  | o_valid / i_ready  | o_data  (t_out)     | one parity byte per item
//
//  One message byte is taken every clock while o_ready is high; the LFSR
//  update of the 16-byte remainder settles in the front end within that cycle.
//  A last byte hands the remainder to a two-entry block queue; the back end
//  then sends 16 parity items, one per clock while i_ready is high, moving
//  each block from the queue through its block register to the output register.
//  o_ready falls only while both queue entries hold unsent blocks.
//  Reset (synchronous, active low) clears the remainder, empties the queue and idles the back end.
module rs_255_239_parity_encoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rse_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output rse_pkg::t_out  o_data
);
    import rse_pkg::*;

    t_block push_block;
    t_block pop_block;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;

    // front end: accept bytes, run the division, hand off finished blocks
    rse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_full  (q_full),
        .o_push  (push),
        .o_block (push_block)
    );

    // hold up to two blocks so either side may stall alone
    rse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_block (push_block),
        .i_pop   (pop),
        .o_block (pop_block),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back end: serialise each block, index 0 first
    rse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_block (pop_block),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
